@@ rtl/tct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg
// Shared codes and types for the TFTP client transfer engine: packet opcodes,
// result actions, status codes and the result record.
// ----------------------------------------------------------------------------
package tct_pkg;

   // Default data bytes in a full block
   localparam int MAXDATA = 512;

   // Valid opcode range
   localparam logic [15:0] OP_MIN = 16'd1;
   localparam logic [15:0] OP_MAX = 16'd5;

   // Packet opcodes
   localparam logic [15:0] OPC_RRQ   = 16'd1;
   localparam logic [15:0] OPC_WRQ   = 16'd2;
   localparam logic [15:0] OPC_DATA  = 16'd3;
   localparam logic [15:0] OPC_ACK   = 16'd4;
   localparam logic [15:0] OPC_ERROR = 16'd5;

   // Last opcode sent, as held in the session state
   localparam logic [2:0] SENT_NONE  = 3'd0;
   localparam logic [2:0] SENT_RRQ   = 3'd1;
   localparam logic [2:0] SENT_WRQ   = 3'd2;
   localparam logic [2:0] SENT_DATA  = 3'd3;
   localparam logic [2:0] SENT_ACK   = 3'd4;
   localparam logic [2:0] SENT_ERROR = 3'd5;

   // Input operations
   localparam logic OP_START  = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // Result actions
   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_REQ  = 3'd1;
   localparam logic [2:0] ACT_ACK  = 3'd2;
   localparam logic [2:0] ACT_DATA = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;
   localparam logic [2:0] ACT_HALT = 3'd5;

   // Status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_SHORT     = 4'd1;
   localparam logic [3:0] ST_BAD_OPC   = 4'd2;
   localparam logic [3:0] ST_BOTCH     = 4'd3;
   localparam logic [3:0] ST_PEER_ERR  = 4'd4;
   localparam logic [3:0] ST_OVERSIZE  = 4'd5;
   localparam logic [3:0] ST_ACK_LEN   = 4'd6;
   localparam logic [3:0] ST_ORDER     = 4'd7;
   localparam logic [3:0] ST_INACTIVE  = 4'd8;
   localparam logic [3:0] ST_REFUSED   = 4'd9;

   // Configuration register indexes
   localparam logic REG_DIRECTION = 1'b0;

   // Minimum packet length (header only)
   localparam logic [15:0] HDR_BYTES = 16'd4;

   // One result record
   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] send_block;
      logic [9:0]  send_len;
      logic        store_payload;
      logic [9:0]  payload_len;
      logic [3:0]  status;
      logic [15:0] peer_error_code;
      logic [31:0] total_bytes;
   } rsp_type;

endpackage

@@ rtl/tct_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_req_if
// Request channel: start items and received packet headers, valid/ready.
// ----------------------------------------------------------------------------
interface tct_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] pkt_opcode;
   logic [15:0] pkt_word;
   logic [15:0] pkt_length;
   logic [9:0]  next_read_len;

   modport source (
      output valid, op, pkt_opcode, pkt_word, pkt_length, next_read_len,
      input  ready
   );
   modport sink (
      input  valid, op, pkt_opcode, pkt_word, pkt_length, next_read_len,
      output ready
   );
endinterface

@@ rtl/tct_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_rsp_if
// Response channel: one action record per request, valid/ready.
// ----------------------------------------------------------------------------
interface tct_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] send_block;
   logic [9:0]  send_len;
   logic        store_payload;
   logic [9:0]  payload_len;
   logic [3:0]  status;
   logic [15:0] peer_error_code;
   logic [31:0] total_bytes;

   modport source (
      output valid, action, send_block, send_len, store_payload, payload_len,
             status, peer_error_code, total_bytes,
      input  ready
   );
   modport sink (
      input  valid, action, send_block, send_len, store_payload, payload_len,
             status, peer_error_code, total_bytes,
      output ready
   );
endinterface

@@ rtl/tftp_client_transfer_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_client_transfer_engine
// Client side of a TFTP read or write transfer: session start and checking
// of received packet headers, giving the next action to take.
// ----------------------------------------------------------------------------
// Usage: set transfer_direction over the APB port while idle, send a start
// transaction, then one transaction per received packet header. Each request
// yields exactly one response. The request is captured in the input register
// at the accepting edge and passes on to the result register, which drives the
// response, unless the response side is stalled. A new request is taken every
// cycle while the response side is not stalled; the rate is set by the single
// decode stage that reads and updates the session state.
// A halted session answers every packet with status inactive until the next
// start. Block numbers and the byte total wrap.
// ----------------------------------------------------------------------------
module tftp_client_transfer_engine
   import tct_pkg::*;
#(
   parameter int BLOCK_BYTES = MAXDATA
) (
   input  logic        clock,
   input  logic        reset,
   tct_req_if.sink     req_chan,
   tct_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LenW = $clog2(BLOCK_BYTES + 1);

   // Configuration
   logic direction_ff;

   // Input register
   logic        s1_valid_ff;
   logic        s1_op_ff;
   logic [15:0] s1_opcode_ff;
   logic [15:0] s1_word_ff;
   logic [15:0] s1_length_ff;
   logic [9:0]  s1_read_len_ff;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Session state
   logic            active_ff,        active_in;
   logic [2:0]      last_sent_ff,     last_sent_in;
   logic [15:0]     next_block_ff,    next_block_in;
   logic [LenW-1:0] last_send_len_ff, last_send_len_in;
   logic [31:0]     byte_total_ff,    byte_total_in;

   // Decode helpers
   logic            s1_move;
   logic            halt;
   logic [3:0]      halt_code;
   logic [15:0]     payload;
   logic [15:0]     prev_block;
   logic [LenW-1:0] avail_sat;

   // APB: always ready, single register
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, direction_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == REG_DIRECTION) begin
         direction_ff <= pwdata[0];
      end
   end

   // Handshake: input stage drains into the result register when it is free
   assign s1_move        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_op_ff       <= req_chan.op;
         s1_opcode_ff   <= req_chan.pkt_opcode;
         s1_word_ff     <= req_chan.pkt_word;
         s1_length_ff   <= req_chan.pkt_length;
         s1_read_len_ff <= req_chan.next_read_len;
      end
   end

   // Dispatch one item against the session state
   always_comb begin
      active_in        = active_ff;
      last_sent_in     = last_sent_ff;
      next_block_in    = next_block_ff;
      last_send_len_in = last_send_len_ff;
      byte_total_in    = byte_total_ff;
      rsp_in           = '0;
      halt             = 1'b0;
      halt_code        = ST_OK;

      payload    = s1_length_ff - HDR_BYTES;
      prev_block = next_block_ff - 16'd1;
      if (32'(s1_read_len_ff) > BLOCK_BYTES) begin
         avail_sat = LenW'(BLOCK_BYTES);
      end else begin
         avail_sat = LenW'(s1_read_len_ff);
      end

      if (s1_op_ff == OP_START) begin
         active_in        = 1'b1;
         byte_total_in    = 32'd0;
         last_send_len_in = LenW'(BLOCK_BYTES);
         if (direction_ff) begin
            next_block_in = 16'd0;
            last_sent_in  = SENT_WRQ;
         end else begin
            next_block_in = 16'd1;
            last_sent_in  = SENT_RRQ;
         end
         rsp_in.action = ACT_REQ;
      end else if (!active_ff) begin
         rsp_in.status = ST_INACTIVE;
      end else if (s1_length_ff < HDR_BYTES) begin
         halt      = 1'b1;
         halt_code = ST_SHORT;
      end else if (s1_opcode_ff < OP_MIN || s1_opcode_ff > OP_MAX) begin
         halt      = 1'b1;
         halt_code = ST_BAD_OPC;
      end else if (s1_opcode_ff == OPC_ERROR) begin
         rsp_in.peer_error_code = s1_word_ff;
         halt = 1'b1;
         if (last_sent_ff == SENT_RRQ || last_sent_ff == SENT_WRQ) begin
            halt_code = ST_REFUSED;
         end else if (last_sent_ff == SENT_DATA || last_sent_ff == SENT_ACK ||
                      last_sent_ff == SENT_ERROR) begin
            halt_code = ST_PEER_ERR;
         end else begin
            halt_code = ST_BOTCH;
         end
      end else if (s1_opcode_ff == OPC_DATA &&
                   (last_sent_ff == SENT_RRQ || last_sent_ff == SENT_ACK)) begin
         // Received data: oversize, new block, repeat, or out of order
         if (32'(payload) > BLOCK_BYTES) begin
            halt      = 1'b1;
            halt_code = ST_OVERSIZE;
         end else if (s1_word_ff != next_block_ff && s1_word_ff != prev_block) begin
            halt      = 1'b1;
            halt_code = ST_ORDER;
         end else begin
            if (s1_word_ff == next_block_ff) begin
               next_block_in        = next_block_ff + 16'd1;
               byte_total_in        = byte_total_ff + 32'(payload);
               rsp_in.store_payload = (payload != 16'd0);
            end
            rsp_in.payload_len = payload[9:0];
            rsp_in.send_block  = s1_word_ff;
            last_sent_in       = SENT_ACK;
            if (32'(payload) == BLOCK_BYTES) begin
               rsp_in.action = ACT_ACK;
            end else begin
               rsp_in.action = ACT_DONE;
               active_in     = 1'b0;
            end
         end
      end else if (s1_opcode_ff == OPC_ACK &&
                   (last_sent_ff == SENT_WRQ || last_sent_ff == SENT_DATA)) begin
         // Received ack: send the next block, finish, ignore a repeat, or halt on bad length or order
         if (s1_length_ff != HDR_BYTES) begin
            halt      = 1'b1;
            halt_code = ST_ACK_LEN;
         end else if (s1_word_ff == next_block_ff) begin
            if (s1_read_len_ff == 10'd0 && 32'(last_send_len_ff) < BLOCK_BYTES) begin
               rsp_in.action = ACT_DONE;
               active_in     = 1'b0;
            end else begin
               last_send_len_in  = avail_sat;
               next_block_in     = next_block_ff + 16'd1;
               byte_total_in     = byte_total_ff + 32'(avail_sat);
               last_sent_in      = SENT_DATA;
               rsp_in.action     = ACT_DATA;
               rsp_in.send_block = next_block_ff + 16'd1;
               rsp_in.send_len   = 10'(avail_sat);
            end
         end else if (s1_word_ff != prev_block) begin
            halt      = 1'b1;
            halt_code = ST_ORDER;
         end
      end else begin
         halt      = 1'b1;
         halt_code = ST_BOTCH;
      end

      // Halt: drop the session, keep the last opcode sent
      if (halt) begin
         active_in     = 1'b0;
         rsp_in.action = ACT_HALT;
         rsp_in.status = halt_code;
      end

      rsp_in.total_bytes = byte_total_in;
   end

   // Advance session state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         last_sent_ff     <= SENT_NONE;
         next_block_ff    <= 16'd0;
         last_send_len_ff <= LenW'(BLOCK_BYTES);
         byte_total_ff    <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (s1_move) begin
            active_ff        <= active_in;
            last_sent_ff     <= last_sent_in;
            next_block_ff    <= next_block_in;
            last_send_len_ff <= last_send_len_in;
            byte_total_ff    <= byte_total_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.action          = rsp_ff.action;
   assign rsp_chan.send_block      = rsp_ff.send_block;
   assign rsp_chan.send_len        = rsp_ff.send_len;
   assign rsp_chan.store_payload   = rsp_ff.store_payload;
   assign rsp_chan.payload_len     = rsp_ff.payload_len;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.peer_error_code = rsp_ff.peer_error_code;
   assign rsp_chan.total_bytes     = rsp_ff.total_bytes;

   // Checks
   a_halt_drops_session: assert property (@(posedge clock) disable iff (reset)
      s1_move && rsp_in.action == ACT_HALT |=> !active_ff)
      else $error("session still active after halt");

   a_start_opens_session: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_op_ff == OP_START |=> active_ff && byte_total_ff == 32'd0)
      else $error("start did not open a clean session");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("request stalled with empty result register");

   a_inactive_no_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_INACTIVE |-> rsp_ff.action == ACT_NONE)
      else $error("inactive status with an action");

endmodule
